@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

@@ rtl/tlh_pkg.sv @@
// shared types and constants for the target lock block
package tlh_pkg;

    localparam int ID_BITS     = 8;
    localparam int LENGTH_BITS = 10;
    localparam int CNT_BITS    = 4;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    localparam logic [CNT_BITS-1:0] CONFIRM_RESET  = CNT_BITS'(5);
    localparam logic [CNT_BITS-1:0] COOLDOWN_RESET = CNT_BITS'(5);
    localparam logic [CNT_BITS-1:0] CNT_MAX        = {CNT_BITS{1'b1}};

    // register index codes, taken from paddr[2]
    localparam logic REG_CONFIRM  = 1'b0;
    localparam logic REG_COOLDOWN = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]     tracker_id;
        logic                   tracker_valid;
        logic                   unstruck;
        logic [LENGTH_BITS-1:0] history_length;
        logic                   frame_last;
    } tlh_in_t;

    typedef struct packed {
        logic               target_valid;
        logic [ID_BITS-1:0] target_id;
    } tlh_out_t;

endpackage

@@ rtl/target_lock_hysteresis.sv @@
// target lock selection with switch hysteresis, top level
//
// The block takes one tracker transaction per clock cycle while item_ready is
// high and gives one result transaction per frame, on the tracker marked
// frame_last. A tracker is held in the input register, then a single pass of
// compare-and-select logic folds it into the running best candidate (longest
// history among valid, unstruck trackers; the first one wins a tie) and, on
// the last tracker of a frame, applies the lock rules: no candidate keeps a
// lock that was seen or drops it; a lock that was not seen is replaced by the
// best candidate; a best equal to the lock or a running cooldown keeps the
// lock; else the candidate must stay best for confirm_frames frames in a row
// before the lock switches, which reloads cooldown_length. A result is
// registered as its last tracker leaves the input register; the rate is set
// by the single-pass update of the running-best and lock registers. The
// result register holds one result, so while a result waits the next frame
// still streams in up to its last tracker, which then waits in the input
// register and holds off further trackers until the result is taken. An
// invalid tracker with frame_last set closes an empty frame. Configuration
// is written over the APB-style port (confirm_frames at 0x0, cooldown_length
// at 0x4); the user must write it only while the block is idle (unenforced).
module target_lock_hysteresis
(
    input  logic                          clk,
    input  logic                          rst_n,
    // tracker transactions
    input  logic                          item_valid,
    output logic                          item_ready,
    input  tlh_pkg::tlh_in_t              item,
    // per-frame result transactions
    output logic                          result_valid,
    input  logic                          result_ready,
    output tlh_pkg::tlh_out_t             result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlh_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tlh_pkg::DATA_BITS-1:0] pwdata,
    output logic [tlh_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import tlh_pkg::*;

    // configuration registers
    logic [CNT_BITS-1:0] confirm_reg;
    logic [CNT_BITS-1:0] cooldown_len_reg;

    // input register stage
    logic    stage_valid_reg;
    tlh_in_t stage_reg;
    logic    stage_go;

    // lock state
    logic                   lock_present_reg, lock_present_next;
    logic [ID_BITS-1:0]     lock_id_reg, lock_id_next;
    logic                   pending_present_reg, pending_present_next;
    logic [ID_BITS-1:0]     pending_id_reg, pending_id_next;
    logic [CNT_BITS-1:0]    pending_count_reg, pending_count_next;
    logic [CNT_BITS-1:0]    cooldown_left_reg, cooldown_left_next;

    // running frame state
    logic                   best_present_reg, best_present_next;
    logic [ID_BITS-1:0]     best_id_reg, best_id_next;
    logic [LENGTH_BITS-1:0] best_length_reg, best_length_next;
    logic                   lock_seen_reg, lock_seen_next;

    // result register
    logic     result_valid_reg;
    tlh_out_t result_reg, result_next;

    // values after folding in the staged tracker
    logic                   fold_present;
    logic [ID_BITS-1:0]     fold_id;
    logic [LENGTH_BITS-1:0] fold_length;
    logic                   fold_seen;
    logic [CNT_BITS-1:0]    cooldown_tick;
    logic [CNT_BITS-1:0]    count_try;
    logic                   out_free;
    logic                   cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_CONFIRM:  prdata = DATA_BITS'(confirm_reg);
            REG_COOLDOWN: prdata = DATA_BITS'(cooldown_len_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg      <= CONFIRM_RESET;
            cooldown_len_reg <= COOLDOWN_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CONFIRM)
            begin
                confirm_reg <= pwdata[CNT_BITS-1:0];
            end
            else
            begin
                cooldown_len_reg <= pwdata[CNT_BITS-1:0];
            end
        end
    end

    // ---------------- handshake ----------------
    // the result slot is free when empty or drained this cycle
    assign out_free     = !result_valid_reg || result_ready;
    // a staged tracker moves on unless it closes a frame and the slot is full
    assign stage_go     = stage_valid_reg && (!stage_reg.frame_last || out_free);
    assign item_ready   = !stage_valid_reg || stage_go;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- fold tracker into running best ----------------
    always_comb
    begin
        fold_present = best_present_reg;
        fold_id      = best_id_reg;
        fold_length  = best_length_reg;
        fold_seen    = lock_seen_reg;
        if (stage_reg.tracker_valid)
        begin
            if (lock_present_reg && stage_reg.tracker_id == lock_id_reg)
            begin
                fold_seen = 1'b1;
            end
            // strictly longer history wins, so a tie keeps the earlier one
            if (stage_reg.unstruck &&
                (!best_present_reg || stage_reg.history_length > best_length_reg))
            begin
                fold_present = 1'b1;
                fold_id      = stage_reg.tracker_id;
                fold_length  = stage_reg.history_length;
            end
        end
    end

    // ---------------- end-of-frame rules ----------------
    assign cooldown_tick = (cooldown_left_reg == '0) ? '0 : cooldown_left_reg - 1'b1;

    // candidate count if this frame continues the pending one, saturating
    assign count_try = (pending_present_reg && pending_id_reg == fold_id) ?
                       ((pending_count_reg == CNT_MAX) ? CNT_MAX : pending_count_reg + 1'b1) :
                       CNT_BITS'(1);

    always_comb
    begin
        lock_present_next    = lock_present_reg;
        lock_id_next         = lock_id_reg;
        pending_present_next = pending_present_reg;
        pending_id_next      = pending_id_reg;
        pending_count_next   = pending_count_reg;
        cooldown_left_next   = cooldown_left_reg;
        best_present_next    = fold_present;
        best_id_next         = fold_id;
        best_length_next     = fold_length;
        lock_seen_next       = fold_seen;
        result_next          = '0;

        if (stage_reg.frame_last)
        begin
            // frame state restarts after every frame
            best_present_next = 1'b0;
            best_id_next      = '0;
            best_length_next  = '0;
            lock_seen_next    = 1'b0;
            // pending clears in every branch but the unconfirmed candidate
            pending_present_next = 1'b0;
            pending_id_next      = '0;
            pending_count_next   = '0;

            if (!fold_present)
            begin
                // no candidate this frame
                cooldown_left_next = cooldown_tick;
                if (fold_seen)
                begin
                    result_next.target_valid = 1'b1;
                    result_next.target_id    = lock_id_reg;
                end
                else
                begin
                    lock_present_next = 1'b0;
                    lock_id_next      = '0;
                end
            end
            else if (!fold_seen)
            begin
                // lock lost or never held: take the best at once
                lock_present_next        = 1'b1;
                lock_id_next             = fold_id;
                cooldown_left_next       = '0;
                result_next.target_valid = 1'b1;
                result_next.target_id    = fold_id;
            end
            else if (lock_id_reg == fold_id || cooldown_left_reg != '0)
            begin
                // best is the lock, or switching still blocked
                cooldown_left_next       = cooldown_tick;
                result_next.target_valid = 1'b1;
                result_next.target_id    = lock_id_reg;
            end
            else if (count_try >= confirm_reg)
            begin
                // candidate confirmed: switch and start cooldown
                lock_present_next        = 1'b1;
                lock_id_next             = fold_id;
                cooldown_left_next       = cooldown_len_reg;
                result_next.target_valid = 1'b1;
                result_next.target_id    = fold_id;
            end
            else
            begin
                // keep counting the candidate, report the lock
                pending_present_next     = 1'b1;
                pending_id_next          = fold_id;
                pending_count_next       = count_try;
                result_next.target_valid = 1'b1;
                result_next.target_id    = lock_id_reg;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg     <= 1'b0;
            result_valid_reg    <= 1'b0;
            lock_present_reg    <= 1'b0;
            lock_id_reg         <= '0;
            pending_present_reg <= 1'b0;
            pending_id_reg      <= '0;
            pending_count_reg   <= '0;
            cooldown_left_reg   <= '0;
            best_present_reg    <= 1'b0;
            best_id_reg         <= '0;
            best_length_reg     <= '0;
            lock_seen_reg       <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (stage_go)
            begin
                lock_present_reg    <= lock_present_next;
                lock_id_reg         <= lock_id_next;
                pending_present_reg <= pending_present_next;
                pending_id_reg      <= pending_id_next;
                pending_count_reg   <= pending_count_next;
                cooldown_left_reg   <= cooldown_left_next;
                best_present_reg    <= best_present_next;
                best_id_reg         <= best_id_next;
                best_length_reg     <= best_length_next;
                lock_seen_reg       <= lock_seen_next;
            end
            if (stage_go && stage_reg.frame_last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
        if (stage_go && stage_reg.frame_last)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/tlh_checker.sv @@
// port-level checker for the target lock block, bound to the top level
`include "assert_macros.svh"

module tlh_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input tlh_pkg::tlh_out_t             result,
    input logic                          pready
);
    import tlh_pkg::*;

    logic result_stall;
    logic no_target;
    logic id_zero;

    assign result_stall = result_valid && !result_ready;
    assign no_target    = result_valid && !result.target_valid;
    assign id_zero      = (result.target_id == '0);

    // a result without a target carries id zero
    `ASSERT_SAME(a_no_target_zero_id, no_target, id_zero, "target_id nonzero without a target")
    // the configuration port never inserts wait states
    `ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")
    // a stalled result transaction stays offered
    `ASSERT_NEXT(a_result_held, result_stall, result_valid, "result withdrawn before taken")
    // and keeps its payload
    `ASSERT_NEXT(a_result_stable, result_stall, $stable(result), "result changed while stalled")

endmodule

bind target_lock_hysteresis tlh_checker u_tlh_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .pready       (pready)
);
